// ===== sv/dpb_pkg.sv =====
// Shared types and constants for the depth pixel back-projection block.
package dpb_pkg;

  localparam int unsigned ColW          = 12;
  localparam int unsigned PhaseW        = 6;
  localparam int unsigned DepthW        = 16;
  localparam int unsigned SizeW         = 13;
  localparam int unsigned CentreW       = 16;
  localparam int unsigned FocW          = 24;
  localparam int unsigned CfgIdxW       = 4;
  localparam int unsigned CfgDataW      = 24;
  localparam int unsigned StrideDefault = 10;

  // Queue between front and back end
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAddrW = 2;
  localparam int unsigned QCntW  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth  = 4'd0,
    CfgImageHeight = 4'd1,
    CfgCenterX     = 4'd2,
    CfgCenterY     = 4'd3,
    CfgInvFocalX   = 4'd4,
    CfgInvFocalY   = 4'd5,
    CfgNearLimit   = 4'd6,
    CfgFarLimit    = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [SizeW-1:0]   image_width;
    logic [SizeW-1:0]   image_height;
    logic [CentreW-1:0] center_x;
    logic [CentreW-1:0] center_y;
    logic [FocW-1:0]    inv_focal_x;
    logic [FocW-1:0]    inv_focal_y;
    logic [DepthW-1:0]  near_limit;
    logic [DepthW-1:0]  far_limit;
  } cfg_t;

  // Kept pixel handed from front to back end
  typedef struct packed {
    logic [ColW-1:0]   col;
    logic [ColW-1:0]   row;
    logic [DepthW-1:0] z;
  } pix_t;

  typedef struct packed {
    logic [DepthW-1:0] z;
    logic [DepthW-1:0] y;
    logic [DepthW-1:0] x;
  } point_t;

  // Queue status seen by the front and back end
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== sv/dpb_front.sv =====
// Front end: raster counters, stride phases and depth range classification.
module dpb_front #(
  parameter int unsigned STRIDE = dpb_pkg::StrideDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dpb_pkg::cfg_t               cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dpb_pkg::DepthW-1:0]  depth_i,
  input  logic                        frame_start_i,
  input  dpb_pkg::q_stat_t            q_stat_i,
  output logic                        push_o,
  output dpb_pkg::pix_t               push_data_o
);

  localparam logic [dpb_pkg::PhaseW-1:0] StrideP = dpb_pkg::PhaseW'(STRIDE);

  logic [dpb_pkg::ColW-1:0]   col_q, col_d, row_q, row_d, col_e, row_e;
  logic [dpb_pkg::PhaseW-1:0] cph_q, cph_d, rph_q, rph_d, cph_e, rph_e;
  logic [dpb_pkg::ColW:0]     ncol, nrow;
  logic                       accept, kept, col_wrap, row_wrap;

  function automatic logic [dpb_pkg::PhaseW-1:0] phase_next(
    input logic [dpb_pkg::PhaseW-1:0] p
  );
    logic [dpb_pkg::PhaseW-1:0] n;
    n = p + 1'b1;
    return (n >= StrideP) ? '0 : n;
  endfunction

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;

  always_comb begin
    col_e = frame_start_i ? '0 : col_q;
    row_e = frame_start_i ? '0 : row_q;
    cph_e = frame_start_i ? '0 : cph_q;
    rph_e = frame_start_i ? '0 : rph_q;

    kept = (cph_e == '0) && (rph_e == '0) &&
           (depth_i >= cfg_i.near_limit) && (depth_i <= cfg_i.far_limit);

    ncol     = {1'b0, col_e} + 1'b1;
    nrow     = {1'b0, row_e} + 1'b1;
    col_wrap = (ncol >= cfg_i.image_width) || ncol[dpb_pkg::ColW];
    row_wrap = (nrow >= cfg_i.image_height) || nrow[dpb_pkg::ColW];

    col_d = col_q;
    row_d = row_q;
    cph_d = cph_q;
    rph_d = rph_q;
    if (accept) begin
      row_d = row_e;
      rph_d = rph_e;
      if (col_wrap) begin
        col_d = '0;
        cph_d = '0;
        if (row_wrap) begin
          row_d = '0;
          rph_d = '0;
        end else begin
          row_d = nrow[dpb_pkg::ColW-1:0];
          rph_d = phase_next(rph_e);
        end
      end else begin
        col_d = ncol[dpb_pkg::ColW-1:0];
        cph_d = phase_next(cph_e);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      cph_q <= '0;
      rph_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      cph_q <= cph_d;
      rph_q <= rph_d;
    end
  end

  assign push_o            = accept && kept;
  assign push_data_o.col   = col_e;
  assign push_data_o.row   = row_e;
  assign push_data_o.z     = depth_i;

endmodule

// ===== sv/dpb_queue.sv =====
// Short FIFO of kept pixels between the front and back end.
module dpb_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dpb_pkg::pix_t     push_data_i,
  input  logic              pop_i,
  output dpb_pkg::pix_t     pop_data_o,
  output dpb_pkg::q_stat_t  stat_o
);

  dpb_pkg::pix_t               mem_q [dpb_pkg::QDepth];
  logic [dpb_pkg::QAddrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [dpb_pkg::QCntW-1:0]   cnt_q, cnt_d;
  logic                        do_push, do_pop;

  assign stat_o.full  = (cnt_q == dpb_pkg::QCntW'(dpb_pkg::QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/dpb_back.sv =====
// Back end: centre offset, two multiplier stages, limit check and output register.
module dpb_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dpb_pkg::cfg_t     cfg_i,
  input  dpb_pkg::q_stat_t  q_stat_i,
  input  dpb_pkg::pix_t     q_data_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dpb_pkg::point_t   out_data_o
);

  localparam int unsigned DW  = dpb_pkg::DepthW;
  localparam int unsigned P1W = 2 * DW;
  localparam int unsigned P2W = P1W + dpb_pkg::FocW;
  localparam int unsigned Sh  = 28;

  logic en;

  // stage 1: sign and magnitude of the offset to the optical centre
  logic          v1_q;
  logic          xneg1_q, yneg1_q;
  logic [DW-1:0] xmag1_q, ymag1_q, z1_q;
  logic [DW:0]   dx, dy;

  // stage 2: offset times depth
  logic           v2_q;
  logic           xneg2_q, yneg2_q;
  logic [P1W-1:0] xp1_q, yp1_q;
  logic [DW-1:0]  z2_q;

  // stage 3: times reciprocal focal length
  logic           v3_q;
  logic           xneg3_q, yneg3_q;
  logic [P2W-1:0] xp2_q, yp2_q;
  logic [DW-1:0]  z3_q;

  logic            out_valid_q;
  dpb_pkg::point_t out_q;
  logic            pass;

  function automatic logic axis_ok(
    input logic           neg,
    input logic [P2W-1:0] prod,
    input logic [DW-1:0]  near,
    input logic [DW-1:0]  far
  );
    logic [P2W-Sh-1:0] v;
    v = prod[P2W-1:Sh];
    return !(neg && (prod != '0)) &&
           (v >= (P2W-Sh)'(near)) && (v <= (P2W-Sh)'(far));
  endfunction

  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en && !q_stat_i.empty;

  assign dx = {1'b0, q_data_i.col, 4'b0000} - {1'b0, cfg_i.center_x};
  assign dy = {1'b0, q_data_i.row, 4'b0000} - {1'b0, cfg_i.center_y};

  assign pass = axis_ok(xneg3_q, xp2_q, cfg_i.near_limit, cfg_i.far_limit) &&
                axis_ok(yneg3_q, yp2_q, cfg_i.near_limit, cfg_i.far_limit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= !q_stat_i.empty;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q && pass;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xneg1_q <= dx[DW];
      yneg1_q <= dy[DW];
      xmag1_q <= dx[DW] ? DW'(-dx) : dx[DW-1:0];
      ymag1_q <= dy[DW] ? DW'(-dy) : dy[DW-1:0];
      z1_q    <= q_data_i.z;

      xneg2_q <= xneg1_q;
      yneg2_q <= yneg1_q;
      xp1_q   <= P1W'(xmag1_q) * P1W'(z1_q);
      yp1_q   <= P1W'(ymag1_q) * P1W'(z1_q);
      z2_q    <= z1_q;

      xneg3_q <= xneg2_q;
      yneg3_q <= yneg2_q;
      xp2_q   <= P2W'(xp1_q) * P2W'(cfg_i.inv_focal_x);
      yp2_q   <= P2W'(yp1_q) * P2W'(cfg_i.inv_focal_y);
      z3_q    <= z2_q;

      out_q.x <= xp2_q[Sh+DW-1:Sh];
      out_q.y <= yp2_q[Sh+DW-1:Sh];
      out_q.z <= z3_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/depth_pixel_backprojection.sv =====
// Top level: configuration registers, front end, queue and back end.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: depth_sample; tuser: frame_start
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: point_x, point_y, point_z
//  cfg       in   cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
//  One depth pixel per cycle is taken while the four-entry queue has room.
//  A kept pixel passes from the queue through the offset stage, depth multiplier,
//  focal multiplier and limit check into the output register.
//  Reset clears the counters, queue, stage valids and the output valid.
//  A stalled output holds all back-end stages; the front end keeps taking
//  pixels until the queue fills, and rejected pixels never enter the queue.
module depth_pixel_backprojection #(
  parameter int unsigned STRIDE = dpb_pkg::StrideDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // [15:0] depth_sample
  input  logic                          s_axis_tuser,  // [0] frame_start
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [47:0]                   m_axis_tdata,  // [15:0] point_x, [31:16] point_y,
                                                       // [47:32] point_z
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dpb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dpb_pkg::CfgDataW-1:0]  cfg_data_i
);

  dpb_pkg::cfg_t    cfg_q;
  dpb_pkg::q_stat_t q_stat;
  dpb_pkg::pix_t    push_data, pop_data;
  dpb_pkg::point_t  point;
  logic             push, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= 13'd640;
      cfg_q.image_height <= 13'd480;
      cfg_q.center_x     <= 16'd5120;
      cfg_q.center_y     <= 16'd3840;
      cfg_q.inv_focal_x  <= 24'd31957;
      cfg_q.inv_focal_y  <= 24'd31957;
      cfg_q.near_limit   <= 16'd41;
      cfg_q.far_limit    <= 16'd20480;
    end else if (cfg_valid_i) begin
      case (dpb_pkg::cfg_idx_e'(cfg_index_i))
        dpb_pkg::CfgImageWidth:  cfg_q.image_width  <= cfg_data_i[dpb_pkg::SizeW-1:0];
        dpb_pkg::CfgImageHeight: cfg_q.image_height <= cfg_data_i[dpb_pkg::SizeW-1:0];
        dpb_pkg::CfgCenterX:     cfg_q.center_x     <= cfg_data_i[dpb_pkg::CentreW-1:0];
        dpb_pkg::CfgCenterY:     cfg_q.center_y     <= cfg_data_i[dpb_pkg::CentreW-1:0];
        dpb_pkg::CfgInvFocalX:   cfg_q.inv_focal_x  <= cfg_data_i[dpb_pkg::FocW-1:0];
        dpb_pkg::CfgInvFocalY:   cfg_q.inv_focal_y  <= cfg_data_i[dpb_pkg::FocW-1:0];
        dpb_pkg::CfgNearLimit:   cfg_q.near_limit   <= cfg_data_i[dpb_pkg::DepthW-1:0];
        dpb_pkg::CfgFarLimit:    cfg_q.far_limit    <= cfg_data_i[dpb_pkg::DepthW-1:0];
        default: ;
      endcase
    end
  end

  dpb_front #(
    .STRIDE (STRIDE)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .depth_i       (s_axis_tdata),
    .frame_start_i (s_axis_tuser),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  dpb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  dpb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_stat_i    (q_stat),
    .q_data_i    (pop_data),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (point)
  );

  assign m_axis_tdata = point;

endmodule

// ===== sv/dpb_checker.sv =====
// Port-level checker for the back-projection block, bound to the top level.
module dpb_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [47:0]  m_axis_tdata
);

  // stalled result keeps valid
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped under stall");

  // stalled result keeps its data
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output data changed under stall");

  // reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // a result needs the full four-stage path out of reset
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(rst_ni, 4) && $past(rst_ni, 1))
    else $error("result appeared too soon after reset");

endmodule

bind depth_pixel_backprojection dpb_checker u_dpb_checker (.*);

// ===== test/depth_pixel_backprojection_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for depth_pixel_backprojection: directed and random depth streams.

class point_scoreboard;
  dpb_pkg::cfg_t                regs;
  logic [dpb_pkg::ColW-1:0]     col_count;
  logic [dpb_pkg::ColW-1:0]     row_count;
  logic [dpb_pkg::PhaseW-1:0]   col_phase;
  logic [dpb_pkg::PhaseW-1:0]   row_phase;
  dpb_pkg::point_t              pending_points[$];
  int unsigned                  points_predicted;
  int unsigned                  errors;

  function new();
    regs.image_width  = 13'd640;
    regs.image_height = 13'd480;
    regs.center_x     = 16'd5120;
    regs.center_y     = 16'd3840;
    regs.inv_focal_x  = 24'd31957;
    regs.inv_focal_y  = 24'd31957;
    regs.near_limit   = 16'd41;
    regs.far_limit    = 16'd20480;
    col_count = '0;
    row_count = '0;
    col_phase = '0;
    row_phase = '0;
    points_predicted = 0;
    errors = 0;
  endfunction

  function int unsigned outstanding();
    return pending_points.size();
  endfunction

  task report(string what);
    $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  function void write_reg(logic [dpb_pkg::CfgIdxW-1:0] idx, logic [dpb_pkg::CfgDataW-1:0] data);
    case (idx)
      dpb_pkg::CfgImageWidth:  regs.image_width  = data[dpb_pkg::SizeW-1:0];
      dpb_pkg::CfgImageHeight: regs.image_height = data[dpb_pkg::SizeW-1:0];
      dpb_pkg::CfgCenterX:     regs.center_x     = data[dpb_pkg::CentreW-1:0];
      dpb_pkg::CfgCenterY:     regs.center_y     = data[dpb_pkg::CentreW-1:0];
      dpb_pkg::CfgInvFocalX:   regs.inv_focal_x  = data[dpb_pkg::FocW-1:0];
      dpb_pkg::CfgInvFocalY:   regs.inv_focal_y  = data[dpb_pkg::FocW-1:0];
      dpb_pkg::CfgNearLimit:   regs.near_limit   = data[dpb_pkg::DepthW-1:0];
      dpb_pkg::CfgFarLimit:    regs.far_limit    = data[dpb_pkg::DepthW-1:0];
      default: ;
    endcase
  endfunction

  function logic [dpb_pkg::PhaseW-1:0] next_phase(logic [dpb_pkg::PhaseW-1:0] p);
    logic [dpb_pkg::PhaseW-1:0] n;
    n = p + 1'b1;
    return (n >= dpb_pkg::StrideDefault) ? '0 : n;
  endfunction

  // Offset (Q12.4) * z (Q4.12) * 1/f (Q0.24) has 40 fraction bits; keep 12.
  function bit project_axis(input logic [dpb_pkg::ColW-1:0] pos,
                            input logic [dpb_pkg::CentreW-1:0] centre,
                            input logic [dpb_pkg::DepthW-1:0] z,
                            input logic [dpb_pkg::FocW-1:0] inv_f,
                            output logic [dpb_pkg::DepthW-1:0] coord);
    longint offset, depth, recip, prod;
    coord  = '0;
    offset = {pos, 4'b0000};
    offset = offset - longint'(centre);
    depth  = z;
    recip  = inv_f;
    prod   = offset * depth * recip;
    if (prod < 0) return 1'b0;
    prod = prod >>> 28;
    if (prod < longint'(regs.near_limit) || prod > longint'(regs.far_limit)) return 1'b0;
    coord = prod[dpb_pkg::DepthW-1:0];
    return 1'b1;
  endfunction

  function void note_pixel(logic [dpb_pkg::DepthW-1:0] z, logic frame_start);
    logic [dpb_pkg::DepthW-1:0] px, py;
    dpb_pkg::point_t pt;
    int unsigned ncol, nrow;
    if (frame_start) begin
      col_count = '0;
      row_count = '0;
      col_phase = '0;
      row_phase = '0;
    end
    if (col_phase == 0 && row_phase == 0 &&
        z >= regs.near_limit && z <= regs.far_limit &&
        project_axis(col_count, regs.center_x, z, regs.inv_focal_x, px) &&
        project_axis(row_count, regs.center_y, z, regs.inv_focal_y, py)) begin
      pt.x = px;
      pt.y = py;
      pt.z = z;
      pending_points.insert(pending_points.size(), pt);
      points_predicted++;
    end
    // Advance raster position; a zero size behaves as one, sizes cap at the counter range.
    ncol = col_count + 1;
    if (ncol >= regs.image_width || ncol >= (1 << dpb_pkg::ColW)) begin
      col_count = '0;
      col_phase = '0;
      nrow = row_count + 1;
      if (nrow >= regs.image_height || nrow >= (1 << dpb_pkg::ColW)) begin
        row_count = '0;
        row_phase = '0;
      end else begin
        row_count = dpb_pkg::ColW'(nrow);
        row_phase = next_phase(row_phase);
      end
    end else begin
      col_count = dpb_pkg::ColW'(ncol);
      col_phase = next_phase(col_phase);
    end
  endfunction

  task check_point(dpb_pkg::point_t got);
    dpb_pkg::point_t want;
    if (pending_points.size() == 0) begin
      report($sformatf("unexpected point x=%h y=%h z=%h", got.x, got.y, got.z));
      return;
    end
    want = pending_points.pop_front();
    if (got.x !== want.x) report($sformatf("point_x got %h want %h", got.x, want.x));
    if (got.y !== want.y) report($sformatf("point_y got %h want %h", got.y, want.y));
    if (got.z !== want.z) report($sformatf("point_z got %h want %h", got.z, want.z));
  endtask
endclass

module depth_pixel_backprojection_tb;

  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned DrainCycles   = 16;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned RandomItems   = 680;
  localparam int unsigned SteadyItems   = 120;

  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         s_tvalid  = 1'b0;
  logic                         s_tready;
  logic [15:0]                  s_tdata   = '0;
  logic                         s_tuser   = 1'b0;
  logic                         m_tvalid;
  logic                         m_tready  = 1'b0;
  logic [47:0]                  m_tdata;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [dpb_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [dpb_pkg::CfgDataW-1:0] cfg_data  = '0;

  point_scoreboard points = new();
  dpb_pkg::cfg_t   live_cfg;
  int unsigned     fed_items = 0;
  int unsigned     burst_left = 0;
  int unsigned     stalled_cycles = 0;
  bit              steady_feed = 1'b0;
  bit              hold_req = 1'b0;

  depth_pixel_backprojection dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (m_tvalid && m_tready) points.check_point(m_tdata);
      if (s_tvalid && s_tready) points.note_pixel(s_tdata, s_tuser);
      if (cfg_valid && cfg_ready) points.write_reg(cfg_index, cfg_data);
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
        stalled_cycles = 0;
      else
        stalled_cycles++;
      if (stalled_cycles >= WatchdogLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Output side: random stall patterns, plus one long hold on request.
  initial begin : receiver
    int unsigned mode, span;
    forever begin
      if (hold_req) begin
        repeat (HoldCycles) begin
          @(negedge clk);
          m_tready = 1'b0;
        end
        hold_req = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(4, 64);
        repeat (span) begin
          @(negedge clk);
          case (mode)
            0: m_tready = 1'b1;
            1: m_tready = 1'($urandom_range(0, 1));
            2: m_tready = ($urandom_range(0, 3) == 0);
            default: m_tready = ($urandom_range(0, 7) != 0);
          endcase
        end
      end
    end
  end

  task automatic send_pixel(input logic [15:0] z, input logic frame_start);
    int unsigned gap;
    if (!steady_feed && burst_left == 0) begin
      gap = $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        s_tvalid = 1'b0;
        s_tdata  = 16'($urandom);
        s_tuser  = 1'($urandom);
      end
      burst_left = $urandom_range(1, 48);
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = z;
    s_tuser  = frame_start;
    do @(posedge clk); while (!s_tready);
    if (burst_left > 0) burst_left--;
    fed_items++;
  endtask

  // Drop valid and wait until every point is out and the pipeline has flushed.
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (points.outstanding() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [dpb_pkg::CfgIdxW-1:0] idx,
                           input logic [dpb_pkg::CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_index = dpb_pkg::CfgIdxW'($urandom);
    cfg_data  = dpb_pkg::CfgDataW'($urandom);
  endtask

  // Set unused upper data bits now and then; the register must drop them.
  function automatic logic [dpb_pkg::CfgDataW-1:0] with_junk(
    input logic [dpb_pkg::CfgDataW-1:0] value,
    input int unsigned w
  );
    if ($urandom_range(0, 3) != 0) return value;
    return value | (dpb_pkg::CfgDataW'($urandom) & ({dpb_pkg::CfgDataW{1'b1}} << w));
  endfunction

  task automatic apply_config(input dpb_pkg::cfg_t c);
    wait_drained();
    cfg_write(dpb_pkg::CfgImageWidth,  with_junk(c.image_width, dpb_pkg::SizeW));
    cfg_write(dpb_pkg::CfgImageHeight, with_junk(c.image_height, dpb_pkg::SizeW));
    cfg_write(dpb_pkg::CfgCenterX,     with_junk(c.center_x, dpb_pkg::CentreW));
    cfg_write(dpb_pkg::CfgCenterY,     with_junk(c.center_y, dpb_pkg::CentreW));
    cfg_write(dpb_pkg::CfgInvFocalX,   c.inv_focal_x);
    cfg_write(dpb_pkg::CfgInvFocalY,   c.inv_focal_y);
    cfg_write(dpb_pkg::CfgNearLimit,   with_junk(c.near_limit, dpb_pkg::DepthW));
    cfg_write(dpb_pkg::CfgFarLimit,    with_junk(c.far_limit, dpb_pkg::DepthW));
    if ($urandom_range(0, 2) == 0)
      cfg_write(dpb_pkg::CfgIdxW'($urandom_range(int'(dpb_pkg::CfgFarLimit) + 1,
                                                 (1 << dpb_pkg::CfgIdxW) - 1)),
                dpb_pkg::CfgDataW'($urandom));
    live_cfg = c;
  endtask

  function automatic dpb_pkg::cfg_t make_cfg(input int unsigned w, input int unsigned h,
                                             input int unsigned cx, input int unsigned cy,
                                             input int unsigned fx, input int unsigned fy,
                                             input int unsigned lo, input int unsigned hi);
    dpb_pkg::cfg_t c;
    c.image_width  = dpb_pkg::SizeW'(w);
    c.image_height = dpb_pkg::SizeW'(h);
    c.center_x     = dpb_pkg::CentreW'(cx);
    c.center_y     = dpb_pkg::CentreW'(cy);
    c.inv_focal_x  = dpb_pkg::FocW'(fx);
    c.inv_focal_y  = dpb_pkg::FocW'(fy);
    c.near_limit   = dpb_pkg::DepthW'(lo);
    c.far_limit    = dpb_pkg::DepthW'(hi);
    return c;
  endfunction

  // Mostly small images so kept pixels come often.
  function automatic logic [dpb_pkg::SizeW-1:0] random_size();
    case ($urandom_range(0, 9))
      0: return dpb_pkg::SizeW'($urandom_range(0, (1 << dpb_pkg::SizeW) - 1));
      1: return dpb_pkg::SizeW'($urandom_range(0, 1));
      default: return dpb_pkg::SizeW'($urandom_range(1, 25));
    endcase
  endfunction

  function automatic logic [dpb_pkg::CentreW-1:0] random_centre();
    case ($urandom_range(0, 7))
      0: return dpb_pkg::CentreW'($urandom);
      1: return '1;
      default: return dpb_pkg::CentreW'($urandom_range(0, 96));
    endcase
  endfunction

  function automatic logic [dpb_pkg::FocW-1:0] random_focal();
    case ($urandom_range(0, 9))
      0: return dpb_pkg::FocW'($urandom);
      1: return '0;
      2: return '1;
      default: return dpb_pkg::FocW'($urandom_range(0, 24'h3FFFF));
    endcase
  endfunction

  function automatic dpb_pkg::cfg_t random_cfg();
    dpb_pkg::cfg_t c;
    c.image_width  = random_size();
    c.image_height = random_size();
    c.center_x     = random_centre();
    c.center_y     = random_centre();
    c.inv_focal_x  = random_focal();
    c.inv_focal_y  = random_focal();
    case ($urandom_range(0, 5))
      0: c.near_limit = dpb_pkg::DepthW'($urandom);
      1: c.near_limit = '1;
      2: c.near_limit = dpb_pkg::DepthW'($urandom_range(0, 64));
      default: c.near_limit = '0;
    endcase
    case ($urandom_range(0, 5))
      0: c.far_limit = dpb_pkg::DepthW'($urandom);
      1: c.far_limit = '0;
      2: c.far_limit = dpb_pkg::DepthW'($urandom_range(16'h8000, 16'hFFFF));
      default: c.far_limit = '1;
    endcase
    return c;
  endfunction

  function automatic logic [15:0] pick_depth(input dpb_pkg::cfg_t c);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return 16'($urandom);
      default: return 16'($urandom_range(c.near_limit, c.far_limit));
    endcase
  endfunction

  task automatic feed(input int unsigned count, input bit open_frame, input bit mid_starts);
    for (int unsigned i = 0; i < count; i++)
      send_pixel(pick_depth(live_cfg),
                 (i == 0 && open_frame) || (mid_starts && $urandom_range(0, 39) == 0));
  endtask

  initial begin : stimulus
    int unsigned base_items;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Power-on settings: centre at column 320, right of column 0, so x goes negative.
    live_cfg = make_cfg(640, 480, 5120, 3840, 31957, 31957, 41, 20480);
    send_pixel(16'h1000, 1'b1);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0000, 1'b1);

    // Zero size: every pixel sits at the origin.
    apply_config(make_cfg(0, 0, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 0, 16'hFFFF));
    send_pixel(16'h0000, 1'b1);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h5555, 1'b1);
    send_pixel(16'hAAAA, 1'b0);

    // Row end, next row off stride, then a frame start in mid-frame.
    apply_config(make_cfg(11, 2, 0, 0, 24'h002000, 24'h002000, 0, 16'hFFFF));
    for (int unsigned i = 0; i < 12; i++)
      send_pixel((i == 0) ? 16'hFFFF : 16'(16'h0800 + i), i == 0);
    send_pixel(16'h4000, 1'b1);

    // Far limit below near limit.
    apply_config(make_cfg(0, 0, 0, 0, 24'h001000, 24'h001000, 16'h8000, 16'h0010));
    send_pixel(16'h8000, 1'b1);
    send_pixel(16'h0010, 1'b0);

    // Zero reciprocal focal length with a nonzero near limit; spare index ignored.
    apply_config(make_cfg(0, 0, 0, 0, 0, 0, 1, 16'hFFFF));
    send_pixel(16'h2000, 1'b1);
    send_pixel(16'h0001, 1'b0);
    wait_drained();
    cfg_write(dpb_pkg::CfgIdxW'((1 << dpb_pkg::CfgIdxW) - 1), '1);
    send_pixel(16'h3000, 1'b0);

    // Every pixel kept while the output holds off: fill the queue, stall the input.
    apply_config(make_cfg(0, 0, 0, 0, $urandom, $urandom, 0, 16'hFFFF));
    steady_feed = 1'b1;
    hold_req = 1'b1;
    feed(SteadyItems, 1'b1, 1'b1);
    steady_feed = 1'b0;

    base_items = fed_items;
    while (fed_items - base_items < RandomItems) begin
      apply_config(random_cfg());
      feed($urandom_range(20, 120), $urandom_range(0, 3) != 0, 1'b1);
    end

    wait_drained();
    if (points.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
